// File: src/egd_pkg.sv
// Package for the unsigned Exp-Golomb stream decoder.
// Holds the channel item types, the per-byte result bank type and sizing constants.
// No dependencies.
`default_nettype none

package egd_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned IDX_W         = 3;
    localparam int unsigned CNT_W         = 4;
    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned ZC_W          = 6;
    localparam int unsigned ZEROS_W       = 5;
    localparam int unsigned SUFFIX_W      = 31;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } egd_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] code_value;
        logic               prefix_error;
        logic               last_of_run;
    } egd_out_t;

    typedef struct packed {
        logic                err;
        logic [ZEROS_W-1:0]  zeros;
        logic [SUFFIX_W-1:0] suffix;
    } egd_code_t;

    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        egd_code_t [BITS_PER_BYTE-1:0]     codes;
    } egd_bank_t;

endpackage

`default_nettype wire

// File: src/exp_golomb_stream_decoder.sv
// Unsigned Exp-Golomb stream decoder, top level. Depends on egd_pkg, egd_scan, egd_queue.
// Path to m_data: input register, result bank register, output register.
// A byte completes 0 to 8 codes; the next byte is scanned as the last code leaves
// the bank, drained one code per cycle via the single result port unless m_ready stalls.
// Reset: synchronous, active low; clears the partial code and empties every stage.
`default_nettype none

module exp_golomb_stream_decoder
    import egd_pkg::*;
#(
    parameter int MAX_PREFIX = 31
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire egd_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output egd_out_t     m_data
);

    logic      in_valid_reg;
    egd_in_t   in_data_reg;
    logic      can_load;
    logic      scan_fire;
    egd_bank_t bank;

    assign scan_fire = in_valid_reg && can_load;
    assign s_ready   = !in_valid_reg || scan_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    egd_scan #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (scan_fire),
        .item    (in_data_reg),
        .bank    (bank)
    );

    egd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (scan_fire),
        .bank_in  (bank),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// File: src/egd_scan.sv
// Bit scanner: holds the partial-code state and decodes one byte in a single pass.
// Produces a bank of up to eight completed codes per byte. Depends on egd_pkg.
`default_nettype none

module egd_scan
    import egd_pkg::*;
#(
    parameter int MAX_PREFIX = 31
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      fire,
    input  wire egd_in_t   item,
    output egd_bank_t      bank
);

    logic                reading_suffix_reg, reading_suffix_next;
    logic [ZC_W-1:0]     zero_count_reg, zero_count_next;
    logic [ZC_W-1:0]     suffix_left_reg, suffix_left_next;
    logic [VALUE_W-1:0]  suffix_acc_reg, suffix_acc_next;

    always_comb begin
        logic             cur_bit;
        logic [CNT_W-1:0] n;
        reading_suffix_next = reading_suffix_reg;
        zero_count_next     = zero_count_reg;
        suffix_left_next    = suffix_left_reg;
        suffix_acc_next     = suffix_acc_reg;
        n                   = '0;
        bank                = '0;
        if (item.restart) begin
            reading_suffix_next = 1'b0;
            zero_count_next     = '0;
            suffix_left_next    = '0;
            suffix_acc_next     = '0;
        end
        for (int b = 0; b < BITS_PER_BYTE; b++) begin
            cur_bit = item.data_byte[IDX_W'(BITS_PER_BYTE - 1 - b)];
            if (!reading_suffix_next) begin
                if (!cur_bit) begin
                    zero_count_next = zero_count_next + ZC_W'(1);
                    if (zero_count_next > ZC_W'(MAX_PREFIX)) begin
                        bank.codes[n[IDX_W-1:0]] = '{err: 1'b1, zeros: '0, suffix: '0};
                        n = n + CNT_W'(1);
                        zero_count_next  = '0;
                        suffix_left_next = '0;
                        suffix_acc_next  = '0;
                    end
                end else if (zero_count_next == '0) begin
                    bank.codes[n[IDX_W-1:0]] = '{err: 1'b0, zeros: '0, suffix: '0};
                    n = n + CNT_W'(1);
                    suffix_left_next = '0;
                    suffix_acc_next  = '0;
                end else begin
                    reading_suffix_next = 1'b1;
                    suffix_left_next    = zero_count_next;
                    suffix_acc_next     = '0;
                end
            end else begin
                suffix_acc_next  = {suffix_acc_next[VALUE_W-2:0], cur_bit};
                suffix_left_next = suffix_left_next - ZC_W'(1);
                if (suffix_left_next == '0) begin
                    bank.codes[n[IDX_W-1:0]] = '{err: 1'b0,
                                                 zeros: zero_count_next[ZEROS_W-1:0],
                                                 suffix: suffix_acc_next[SUFFIX_W-1:0]};
                    n = n + CNT_W'(1);
                    reading_suffix_next = 1'b0;
                    zero_count_next     = '0;
                    suffix_left_next    = '0;
                    suffix_acc_next     = '0;
                end
            end
        end
        bank.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reading_suffix_reg <= 1'b0;
            zero_count_reg     <= '0;
            suffix_left_reg    <= '0;
            suffix_acc_reg     <= '0;
        end else if (fire) begin
            reading_suffix_reg <= reading_suffix_next;
            zero_count_reg     <= zero_count_next;
            suffix_left_reg    <= suffix_left_next;
            suffix_acc_reg     <= suffix_acc_next;
        end
    end

endmodule

`default_nettype wire

// File: src/egd_queue.sv
// Result bank and output stage: drains a byte's completed codes one per cycle unless m_ready stalls.
// Forms each value as 2^zeros - 1 + suffix into the output register. Depends on egd_pkg.
`default_nettype none

module egd_queue
    import egd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      load,
    input  wire egd_bank_t bank_in,
    output logic           can_load,
    output logic           m_valid,
    input  wire logic      m_ready,
    output egd_out_t       m_data
);

    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              idx_reg;
    egd_code_t [BITS_PER_BYTE-1:0] codes_reg;
    logic                          m_valid_reg;
    egd_out_t                      m_data_reg;

    logic      busy;
    logic      pop;
    logic      last;
    egd_code_t cur;
    egd_out_t  out_next;

    assign busy     = idx_reg < cnt_reg;
    assign pop      = busy && (!m_valid_reg || m_ready);
    assign last     = idx_reg == (cnt_reg - CNT_W'(1));
    assign can_load = !busy || (pop && last);
    assign cur      = codes_reg[idx_reg[IDX_W-1:0]];

    always_comb begin
        out_next.code_value   = ((VALUE_W'(1) << cur.zeros) - VALUE_W'(1))
                                + VALUE_W'(cur.suffix);
        out_next.prefix_error = cur.err;
        out_next.last_of_run  = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            cnt_reg <= bank_in.count;
            idx_reg <= '0;
        end else if (pop) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            codes_reg <= bank_in.codes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= cnt_reg)
        else $error("Bank index ran past the bank count.");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(BITS_PER_BYTE))
        else $error("Bank count exceeds the number of bits in a byte.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && busy) |-> (pop && last))
        else $error("Bank reloaded while codes were still pending.");

    a_pop_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_valid_reg)
        else $error("A drained code did not reach the output register.");
`endif

endmodule

`default_nettype wire

// File: verif/tb_exp_golomb_stream_decoder.sv
// Self-checking testbench for exp_golomb_stream_decoder, the unsigned Exp-Golomb byte decoder.
// A clocked driver and monitor with random idling check every result against a built-in model.
// Depends on egd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_exp_golomb_stream_decoder;
    import egd_pkg::*;

    typedef struct {
        egd_in_t item;
        bit      drain_first;
    } pending_byte_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    egd_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    egd_out_t m_data;

    pending_byte_t byte_backlog[$];
    egd_out_t      expected_codes[$];
    bit            stream_bits[$];

    // Decoder model state.
    logic        in_suffix;
    logic [5:0]  zeros_seen;
    logic [5:0]  suffix_remaining;
    logic [31:0] suffix_bits;

    int  errors       = 0;
    int  bytes_sent   = 0;
    int  codes_seen   = 0;
    int  error_codes  = 0;
    int  tx_gap       = 0;
    int  tx_calm      = 0;
    int  rx_gap       = 0;
    int  rx_calm      = 0;
    int  hold_left    = 0;
    bit  hold_request = 1'b0;
    bit  hold_done    = 1'b0;
    bit  drain_next   = 1'b0;
    logic tx_offer;

    exp_golomb_stream_decoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int idle_draw(inout int calm);
        int gap;
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 15) == 0) calm = 25;
        end
        return gap;
    endfunction

    task automatic clear_partial_code();
        in_suffix        = 1'b0;
        zeros_seen       = '0;
        suffix_remaining = '0;
        suffix_bits      = '0;
    endtask

    task automatic emit_code(logic [31:0] value, logic err);
        egd_out_t r;
        r.code_value   = value;
        r.prefix_error = err;
        r.last_of_run  = 1'b0;
        expected_codes.push_back(r);
    endtask

    task automatic decode_byte(egd_in_t item);
        int          produced;
        logic        bit_in;
        logic [32:0] value;
        produced = 0;
        if (item.restart) clear_partial_code();
        for (int b = 7; b >= 0; b--) begin
            bit_in = item.data_byte[b];
            if (!in_suffix) begin
                if (!bit_in) begin
                    zeros_seen = zeros_seen + 6'd1;
                    if (zeros_seen > 6'd31) begin
                        emit_code('0, 1'b1);
                        produced++;
                        clear_partial_code();
                    end
                end else if (zeros_seen == 6'd0) begin
                    emit_code('0, 1'b0);
                    produced++;
                    clear_partial_code();
                end else begin
                    in_suffix        = 1'b1;
                    suffix_remaining = zeros_seen;
                    suffix_bits      = '0;
                end
            end else begin
                suffix_bits      = {suffix_bits[30:0], bit_in};
                suffix_remaining = suffix_remaining - 6'd1;
                if (suffix_remaining == 6'd0) begin
                    value = (33'd1 << zeros_seen[4:0]) - 33'd1 + {1'b0, suffix_bits};
                    emit_code(value[31:0], 1'b0);
                    produced++;
                    clear_partial_code();
                end
            end
        end
        if (produced > 0) expected_codes[expected_codes.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(egd_out_t got);
        egd_out_t want;
        if (expected_codes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
        end else begin
            want = expected_codes.pop_front();
            report_field("code_value", want.code_value, got.code_value);
            report_field("prefix_error", 32'(want.prefix_error), 32'(got.prefix_error));
            report_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
            if (want.prefix_error) error_codes++;
        end
        codes_seen++;
    endtask

    task automatic add_byte(logic [7:0] data, logic restart);
        pending_byte_t p;
        p.item.data_byte = data;
        p.item.restart   = restart;
        p.drain_first    = drain_next;
        drain_next       = 1'b0;
        byte_backlog.push_back(p);
    endtask

    task automatic push_code(int zeros);
        logic [30:0] suffix;
        suffix = 31'($urandom());
        for (int i = 0; i < zeros; i++) stream_bits.push_back(1'b0);
        stream_bits.push_back(1'b1);
        for (int i = zeros - 1; i >= 0; i--) stream_bits.push_back(suffix[i]);
    endtask

    task automatic pack_stream();
        logic [7:0] data;
        while (stream_bits.size() >= 8) begin
            for (int i = 7; i >= 0; i--) data[i] = stream_bits.pop_front();
            add_byte(data, $urandom_range(0, 19) == 0);
        end
    endtask

    task automatic build_stimulus();
        int pick;
        int target;
        add_byte(8'hFF, 1'b1);
        repeat (4) add_byte(8'h00, 1'b0);
        add_byte(8'h80, 1'b0);
        // Longest legal prefix with an all-ones suffix gives the largest value.
        add_byte(8'h00, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFE, 1'b0);
        add_byte(8'h00, 1'b1);
        drain_next = 1'b1;
        add_byte(8'h5F, 1'b1);
        add_byte(8'h00, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h01, 1'b0);
        repeat (4) add_byte(8'h00, 1'b0);
        add_byte(8'h01, 1'b1);

        drain_next = 1'b1;
        target = byte_backlog.size() + 200;
        while (byte_backlog.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (pick < 17) begin
                repeat ($urandom_range(32, 45)) stream_bits.push_back(1'b0);
            end else if (pick < 62) begin
                push_code($urandom_range(0, 3));
            end else if (pick < 90) begin
                push_code($urandom_range(4, 12));
            end else begin
                push_code($urandom_range(13, 31));
            end
            pack_stream();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            tx_gap  <= 0;
        end else begin
            tx_offer = s_valid;
            if (s_valid && s_ready) begin
                decode_byte(s_data);
                bytes_sent++;
                tx_offer = 1'b0;
            end
            if (!tx_offer) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                end else if (byte_backlog.size() > 0 &&
                             !(byte_backlog[0].drain_first && expected_codes.size() != 0)) begin
                    s_data   <= byte_backlog[0].item;
                    tx_offer = 1'b1;
                    tx_gap   <= idle_draw(tx_calm);
                    void'(byte_backlog.pop_front());
                end
            end
            s_valid <= tx_offer;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap  = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
                rx_gap = idle_draw(rx_calm);
                if (codes_seen >= 150) hold_request <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
            m_ready <= (rx_gap == 0) && (hold_left == 0);
        end
    end

    // One long receiver stall so that the decoder backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin
        clear_partial_code();
        build_stimulus();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (byte_backlog.size() != 0 || s_valid) @(posedge aclk);
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("Decoded %0d bytes into %0d checked codes, %0d of them prefix errors.",
                 bytes_sent, codes_seen, error_codes);
        $display("Random idling on both sides, one long output stall, %0d mismatches.", errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d codes still outstanding.", expected_codes.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
